// ===== rtl/core/tcce_pkg.sv =====
// Shared types, constants and codes for the text console cursor engine.
`timescale 1ns / 1ps

package tcce_pkg;

   // Spacing and console constants
   localparam int CHAR_GAP       = 1;
   localparam int LINE_GAP       = 2;
   localparam int TAB_SPACES     = 4;
   localparam int COORD_BITS_DEF = 12;
   localparam int MAX_CMDS       = 8;

   localparam int CNT_W  = $clog2(MAX_CMDS + 1);
   localparam int TAB_W  = $clog2(TAB_SPACES + 1);
   localparam int MUL_W  = 18;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // Character codes
   localparam logic [7:0] CHR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHR_TAB       = 8'h09;
   localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] PRINT_LO      = 8'd32;
   localparam logic [7:0] PRINT_HI      = 8'd127;

   // Register indexes
   localparam logic [2:0] REG_GLYPH_W    = 3'd0;
   localparam logic [2:0] REG_GLYPH_H    = 3'd1;
   localparam logic [2:0] REG_SCALE      = 3'd2;
   localparam logic [2:0] REG_SCREEN_W   = 3'd3;
   localparam logic [2:0] REG_SCREEN_H   = 3'd4;
   localparam logic [2:0] REG_FG_COLOR   = 3'd5;
   localparam logic [2:0] REG_BACK_COLOR = 3'd6;

   // Register reset values
   localparam logic [5:0]  RST_GLYPH_W    = 6'd8;
   localparam logic [5:0]  RST_GLYPH_H    = 6'd16;
   localparam logic [2:0]  RST_SCALE      = 3'd1;
   localparam logic [12:0] RST_SCREEN_W   = 13'd1024;
   localparam logic [12:0] RST_SCREEN_H   = 13'd768;
   localparam logic [23:0] RST_FG_COLOR   = 24'hFFFFFF;
   localparam logic [23:0] RST_BACK_COLOR = 24'h000000;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_SETCUR = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CMD_GLYPH  = 2'd0,
      CMD_FILL   = 2'd1,
      CMD_SCROLL = 2'd2
   } out_cmd_type;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_PRINT,
      CLS_TAB,
      CLS_NEWLINE,
      CLS_BACKSPACE
   } char_class_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_GLYPH,
      DP_SCROLL,
      DP_NEWLINE,
      DP_ERASE,
      DP_MUL,
      DP_SETCUR,
      DP_CLEAR
   } dp_op_type;

   // Saturated and derived geometry
   typedef struct packed {
      logic [7:0]  cell_step;
      logic [7:0]  line_step;
      logic [7:0]  box_w;
      logic [7:0]  box_h;
      logic [12:0] scr_w;
      logic [12:0] scr_h;
      logic [2:0]  scale;
      logic [23:0] fg_color;
      logic [23:0] back_color;
   } geom_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
      logic      last;
   } dp_cmd_type;

   typedef struct packed {
      op_type         opcode;
      char_class_type char_class;
      logic           wrap_scroll;
      logic           nl_scroll;
      logic           at_origin;
      logic           out_free;
   } dp_status_type;

endpackage

// ===== rtl/core/tcce_regs.sv =====
// Configuration register file with saturation and derived glyph geometry.
`timescale 1ns / 1ps

module tcce_regs import tcce_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output geom_type          geom
);

   logic [5:0]  glyph_w_ff;
   logic [5:0]  glyph_h_ff;
   logic [2:0]  scale_ff;
   logic [12:0] screen_w_ff;
   logic [12:0] screen_h_ff;
   logic [23:0] fg_ff;
   logic [23:0] bg_ff;
   geom_type    geom_ff;
   geom_type    geom_in;

   logic        wr_en;
   logic [2:0]  reg_idx;
   logic [5:0]  gw_sat;
   logic [5:0]  gh_sat;
   logic [2:0]  sc_sat;
   logic [12:0] sw_sat;
   logic [12:0] sh_sat;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_w_ff  <= RST_GLYPH_W;
         glyph_h_ff  <= RST_GLYPH_H;
         scale_ff    <= RST_SCALE;
         screen_w_ff <= RST_SCREEN_W;
         screen_h_ff <= RST_SCREEN_H;
         fg_ff       <= RST_FG_COLOR;
         bg_ff       <= RST_BACK_COLOR;
      end else if (wr_en) begin
         case (reg_idx)
            REG_GLYPH_W:    glyph_w_ff  <= csr_pwdata[5:0];
            REG_GLYPH_H:    glyph_h_ff  <= csr_pwdata[5:0];
            REG_SCALE:      scale_ff    <= csr_pwdata[2:0];
            REG_SCREEN_W:   screen_w_ff <= csr_pwdata[12:0];
            REG_SCREEN_H:   screen_h_ff <= csr_pwdata[12:0];
            REG_FG_COLOR:   fg_ff       <= csr_pwdata[23:0];
            REG_BACK_COLOR: bg_ff       <= csr_pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   // Return register contents
   always_comb begin
      case (reg_idx)
         REG_GLYPH_W:    csr_prdata = DATA_W'(glyph_w_ff);
         REG_GLYPH_H:    csr_prdata = DATA_W'(glyph_h_ff);
         REG_SCALE:      csr_prdata = DATA_W'(scale_ff);
         REG_SCREEN_W:   csr_prdata = DATA_W'(screen_w_ff);
         REG_SCREEN_H:   csr_prdata = DATA_W'(screen_h_ff);
         REG_FG_COLOR:   csr_prdata = DATA_W'(fg_ff);
         REG_BACK_COLOR: csr_prdata = DATA_W'(bg_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Clamp register values to their usable ranges
   always_comb begin
      gw_sat = (glyph_w_ff == 6'd0) ? 6'd1 : ((glyph_w_ff > 6'd32) ? 6'd32 : glyph_w_ff);
      gh_sat = (glyph_h_ff == 6'd0) ? 6'd1 : ((glyph_h_ff > 6'd32) ? 6'd32 : glyph_h_ff);
      sc_sat = (scale_ff == 3'd0) ? 3'd1 : ((scale_ff > 3'd4) ? 3'd4 : scale_ff);
      sw_sat = (screen_w_ff == 13'd0) ? 13'd1 :
               ((screen_w_ff > 13'd4096) ? 13'd4096 : screen_w_ff);
      sh_sat = (screen_h_ff == 13'd0) ? 13'd1 :
               ((screen_h_ff > 13'd4096) ? 13'd4096 : screen_h_ff);
   end

   // Form steps and box sizes
   always_comb begin
      geom_in.cell_step  = 8'(({2'b00, gw_sat} + 8'(CHAR_GAP)) * {5'b00000, sc_sat});
      geom_in.line_step  = 8'(({2'b00, gh_sat} + 8'(LINE_GAP)) * {5'b00000, sc_sat});
      geom_in.box_w      = 8'({2'b00, gw_sat} * {5'b00000, sc_sat});
      geom_in.box_h      = 8'({2'b00, gh_sat} * {5'b00000, sc_sat});
      geom_in.scr_w      = sw_sat;
      geom_in.scr_h      = sh_sat;
      geom_in.scale      = sc_sat;
      geom_in.fg_color   = fg_ff;
      geom_in.back_color = bg_ff;
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom = geom_ff;

endmodule

// ===== rtl/core/tcce_dp.sv =====
// Datapath: input latch, cursor registers, position arithmetic and result register.
`timescale 1ns / 1ps

module tcce_dp import tcce_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  geom_type      geom,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [1:0]    req_opcode,
   input  logic [7:0]    req_char_code,
   input  logic [9:0]    req_column,
   input  logic [9:0]    req_row,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_command,
   output logic [11:0]   rsp_pos_x,
   output logic [11:0]   rsp_pos_y,
   output logic [12:0]   rsp_rect_width,
   output logic [12:0]   rsp_rect_height,
   output logic [7:0]    rsp_glyph_code,
   output logic [23:0]   rsp_color,
   output logic [2:0]    rsp_glyph_scale,
   output logic          rsp_last
);

   localparam int CALC_W = (COORD_BITS > MUL_W ? COORD_BITS : MUL_W) + 2;

   // Latched item
   op_type              op_ff;
   logic [7:0]          char_ff;
   logic [9:0]          col_ff;
   logic [9:0]          row_ff;

   // Cursor and set-cursor products
   logic [COORD_BITS-1:0] cx_ff;
   logic [COORD_BITS-1:0] cy_ff;
   logic [CALC_W-1:0]     cx_in;
   logic [CALC_W-1:0]     cy_in;
   logic [MUL_W-1:0]      px_ff;
   logic [MUL_W-1:0]      py_ff;

   // Result register
   logic                rsp_valid_ff;
   out_cmd_type         command_ff;
   logic [11:0]         pos_x_ff;
   logic [11:0]         pos_y_ff;
   logic [12:0]         rect_w_ff;
   logic [12:0]         rect_h_ff;
   logic [7:0]          code_ff;
   logic [23:0]         color_ff;
   logic [2:0]          gscale_ff;
   logic                last_ff;

   logic [CALC_W-1:0]   cx;
   logic [CALC_W-1:0]   cy;
   logic [CALC_W-1:0]   cs;
   logic [CALC_W-1:0]   ls;
   logic [CALC_W-1:0]   bw;
   logic [CALC_W-1:0]   bh;
   logic [CALC_W-1:0]   sw;
   logic [CALC_W-1:0]   sh;
   logic [CALC_W-1:0]   nx;
   logic [CALC_W-1:0]   ny;
   logic [CALC_W-1:0]   nl_y;
   logic [CALC_W-1:0]   right_x;
   logic [CALC_W-1:0]   bottom_y;
   logic [CALC_W-1:0]   px;
   logic [CALC_W-1:0]   py;
   logic                wrap;
   logic                nl_scroll;
   char_class_type      char_class;

   assign cx = CALC_W'(cx_ff);
   assign cy = CALC_W'(cy_ff);
   assign cs = CALC_W'(geom.cell_step);
   assign ls = CALC_W'(geom.line_step);
   assign bw = CALC_W'(geom.box_w);
   assign bh = CALC_W'(geom.box_h);
   assign sw = CALC_W'(geom.scr_w);
   assign sh = CALC_W'(geom.scr_h);
   assign px = CALC_W'(px_ff);
   assign py = CALC_W'(py_ff);

   // Advance and wrap tests
   assign nx        = cx + cs;
   assign ny        = cy + ls;
   assign wrap      = (nx + bw) > sw;
   assign nl_scroll = (ny + bh) > sh;
   assign nl_y      = nl_scroll ? cy : ny;
   assign right_x   = (sw > bw) ? sw - bw : '0;
   assign bottom_y  = (sh > bh) ? sh - bh : '0;

   // Classify the latched character
   always_comb begin
      if (char_ff == CHR_NEWLINE) begin
         char_class = CLS_NEWLINE;
      end else if (char_ff == CHR_TAB) begin
         char_class = CLS_TAB;
      end else if (char_ff == CHR_BACKSPACE) begin
         char_class = CLS_BACKSPACE;
      end else if (char_ff inside {[PRINT_LO:PRINT_HI]}) begin
         char_class = CLS_PRINT;
      end else begin
         char_class = CLS_OTHER;
      end
   end

   assign status.opcode      = op_ff;
   assign status.char_class  = char_class;
   assign status.wrap_scroll = wrap && nl_scroll;
   assign status.nl_scroll   = nl_scroll;
   assign status.at_origin   = (cx_ff == '0) && (cy_ff == '0);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   // Latch the accepted item
   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD) begin
         op_ff   <= op_type'(req_opcode);
         char_ff <= req_char_code;
         col_ff  <= req_column;
         row_ff  <= req_row;
      end
   end

   // Scale column and row to pixels
   always_ff @(posedge clock) begin
      if (cmd.op == DP_MUL) begin
         px_ff <= MUL_W'(col_ff) * MUL_W'(geom.cell_step);
         py_ff <= MUL_W'(row_ff) * MUL_W'(geom.line_step);
      end
   end

   // Next cursor
   always_comb begin
      cx_in = cx;
      cy_in = cy;
      case (cmd.op)
         DP_GLYPH: begin
            if (wrap) begin
               cx_in = '0;
               cy_in = nl_y;
            end else begin
               cx_in = nx;
            end
         end
         DP_NEWLINE: begin
            cx_in = '0;
            cy_in = nl_y;
         end
         DP_ERASE: begin
            if (cx == '0) begin
               cx_in = right_x;
               cy_in = (cy >= ls) ? cy - ls : cy;
            end else begin
               cx_in = (cx > cs) ? cx - cs : '0;
            end
         end
         DP_SETCUR: begin
            cx_in = (px >= sw) ? right_x : px;
            cy_in = (py >= sh) ? bottom_y : py;
         end
         DP_CLEAR: begin
            cx_in = '0;
            cy_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
      end else begin
         cx_ff <= cx_in[COORD_BITS-1:0];
         cy_ff <= cy_in[COORD_BITS-1:0];
      end
   end

   // Hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the result fields
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         last_ff <= cmd.last;
         case (cmd.op)
            DP_GLYPH: begin
               command_ff <= CMD_GLYPH;
               pos_x_ff   <= cx[11:0];
               pos_y_ff   <= cy[11:0];
               rect_w_ff  <= '0;
               rect_h_ff  <= '0;
               code_ff    <= (char_class == CLS_TAB) ? CHR_SPACE : char_ff;
               color_ff   <= geom.fg_color;
               gscale_ff  <= geom.scale;
            end
            DP_ERASE: begin
               // fill the cell the cursor steps back onto
               command_ff <= CMD_FILL;
               pos_x_ff   <= 12'(cx_in[COORD_BITS-1:0]);
               pos_y_ff   <= 12'(cy_in[COORD_BITS-1:0]);
               rect_w_ff  <= 13'(geom.box_w);
               rect_h_ff  <= 13'(geom.box_h);
               code_ff    <= '0;
               color_ff   <= geom.back_color;
               gscale_ff  <= 3'd1;
            end
            DP_CLEAR: begin
               command_ff <= CMD_FILL;
               pos_x_ff   <= '0;
               pos_y_ff   <= '0;
               rect_w_ff  <= geom.scr_w;
               rect_h_ff  <= geom.scr_h;
               code_ff    <= '0;
               color_ff   <= geom.back_color;
               gscale_ff  <= 3'd1;
            end
            default: begin
               command_ff <= CMD_SCROLL;
               pos_x_ff   <= '0;
               pos_y_ff   <= '0;
               rect_w_ff  <= '0;
               rect_h_ff  <= 13'(geom.line_step);
               code_ff    <= '0;
               color_ff   <= geom.back_color;
               gscale_ff  <= 3'd1;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = command_ff;
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_rect_width  = rect_w_ff;
   assign rsp_rect_height = rect_h_ff;
   assign rsp_glyph_code  = code_ff;
   assign rsp_color       = color_ff;
   assign rsp_glyph_scale = gscale_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== rtl/core/tcce_ctrl.sv =====
// Controller: sequences each console operation into datapath steps and commands.
`timescale 1ns / 1ps

module tcce_ctrl import tcce_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_GLYPH,
      S_SCROLL,
      S_NEWLINE,
      S_ERASE,
      S_MUL,
      S_SETCUR,
      S_CLEAR
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [TAB_W-1:0] tab_ff;
   logic [TAB_W-1:0] tab_in;
   logic             tab_mode_ff;
   logic             tab_mode_in;

   logic             room;
   logic             near_full;
   logic             final_space;

   assign room        = count_ff < CNT_W'(MAX_CMDS);
   assign near_full   = count_ff == CNT_W'(MAX_CMDS - 1);
   assign final_space = !tab_mode_ff || (tab_ff == TAB_W'(TAB_SPACES - 1));
   assign req_ready   = (state_ff == S_IDLE);

   // Next state and datapath step
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      tab_in      = tab_ff;
      tab_mode_in = tab_mode_ff;
      cmd.op      = DP_NOP;
      cmd.emit    = 1'b0;
      cmd.last    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op      = DP_LOAD;
               count_in    = '0;
               tab_in      = '0;
               tab_mode_in = 1'b0;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.opcode)
               OP_PUT: begin
                  case (status.char_class)
                     CLS_PRINT:     state_in = S_GLYPH;
                     CLS_TAB: begin
                        tab_mode_in = 1'b1;
                        state_in    = S_GLYPH;
                     end
                     CLS_NEWLINE:   state_in = S_NEWLINE;
                     CLS_BACKSPACE: state_in = S_ERASE;
                     default:       state_in = S_IDLE;
                  endcase
               end
               OP_SETCUR: state_in = S_MUL;
               OP_CLEAR:  state_in = S_CLEAR;
               default:   state_in = S_IDLE;
            endcase
         end
         S_GLYPH: begin
            // past the command limit the cursor still moves, nothing is sent
            if (!room || status.out_free) begin
               cmd.op   = DP_GLYPH;
               cmd.emit = room;
               cmd.last = near_full || (final_space && !status.wrap_scroll);
               if (room) begin
                  count_in = count_ff + 1'b1;
               end
               if (status.wrap_scroll) begin
                  state_in = S_SCROLL;
               end else if (final_space) begin
                  state_in = S_IDLE;
               end else begin
                  tab_in = tab_ff + 1'b1;
               end
            end
         end
         S_SCROLL: begin
            if (!room || status.out_free) begin
               cmd.op   = DP_SCROLL;
               cmd.emit = room;
               cmd.last = near_full || final_space;
               if (room) begin
                  count_in = count_ff + 1'b1;
               end
               if (final_space) begin
                  state_in = S_IDLE;
               end else begin
                  tab_in   = tab_ff + 1'b1;
                  state_in = S_GLYPH;
               end
            end
         end
         S_NEWLINE: begin
            if (!status.nl_scroll || status.out_free) begin
               cmd.op   = DP_NEWLINE;
               cmd.emit = status.nl_scroll;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ERASE: begin
            if (status.at_origin) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.op   = DP_ERASE;
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_MUL: begin
            cmd.op   = DP_MUL;
            state_in = S_SETCUR;
         end
         S_SETCUR: begin
            cmd.op   = DP_SETCUR;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            if (status.out_free) begin
               cmd.op   = DP_CLEAR;
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         tab_ff      <= '0;
         tab_mode_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         tab_ff      <= tab_in;
         tab_mode_ff <= tab_mode_in;
      end
   end

endmodule

// ===== rtl/core/text_console_cursor_engine_unit.sv =====
// Top level of the text console cursor engine.
// Steps: take, decode, then glyph (+ scroll at bottom), newline, erase or clear;
// set cursor multiplies then sets; a tab is a glyph (+ scroll) per space.
// Throughput: one item at a time, set by the controller sequence; each command
// waits in the result register, so a stalled transfer holds the step sequence.
// Reset: synchronous; cursor to 0,0, registers to defaults; no clearing pass.
`timescale 1ns / 1ps

module text_console_cursor_engine_unit import tcce_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // console operations
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_char_code,
   input  logic [9:0]        req_column,
   input  logic [9:0]        req_row,
   // drawing commands
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_command,
   output logic [11:0]       rsp_pos_x,
   output logic [11:0]       rsp_pos_y,
   output logic [12:0]       rsp_rect_width,
   output logic [12:0]       rsp_rect_height,
   output logic [7:0]        rsp_glyph_code,
   output logic [23:0]       rsp_color,
   output logic [2:0]        rsp_glyph_scale,
   output logic              rsp_last,
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   geom_type      geom;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tcce_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .geom        (geom)
   );

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   tcce_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .geom            (geom),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .req_opcode      (req_opcode),
      .req_char_code   (req_char_code),
      .req_column      (req_column),
      .req_row         (req_row),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_command     (rsp_command),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_rect_width  (rsp_rect_width),
      .rsp_rect_height (rsp_rect_height),
      .rsp_glyph_code  (rsp_glyph_code),
      .rsp_color       (rsp_color),
      .rsp_glyph_scale (rsp_glyph_scale),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== dv/text_console_cursor_engine_unit_tb.sv =====
// Self-checking testbench for the text console cursor engine: table, random ops, APB setup.
`timescale 1ns / 1ps

module text_console_cursor_engine_unit_tb;
   import tcce_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;
   localparam int SETTLE_CYCLES  = 24;
   localparam int NUM_DIRECTED   = 23;
   localparam int PRINT_LIMIT    = 40;

   // One drawing command as it leaves the block
   typedef struct packed {
      out_cmd_type cmd;
      logic [11:0] x;
      logic [11:0] y;
      logic [12:0] w;
      logic [12:0] h;
      logic [7:0]  code;
      logic [23:0] color;
      logic [2:0]  gscale;
      logic        last;
   } draw_cmd_type;

   // One console operation; typed rows carry their own expectation
   typedef struct packed {
      op_type       op;
      logic [7:0]   ch;
      logic [9:0]   col;
      logic [9:0]   row;
      logic         typed;
      logic         has_draw;
      draw_cmd_type draw;
   } stim_row_type;

   localparam draw_cmd_type NO_DRAW = '0;
   localparam draw_cmd_type DRAW_A_AT_ORIGIN =
      '{CMD_GLYPH, 12'd0, 12'd0, 13'd0, 13'd0, 8'h41, RST_FG_COLOR, 3'd1, 1'b1};
   localparam draw_cmd_type CLEAR_AT_RESET =
      '{CMD_FILL, 12'd0, 12'd0, RST_SCREEN_W, RST_SCREEN_H, 8'd0, RST_BACK_COLOR, 3'd1, 1'b1};

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_opcode;
   logic [7:0]        req_char_code;
   logic [9:0]        req_column;
   logic [9:0]        req_row;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [1:0]        rsp_command;
   logic [11:0]       rsp_pos_x;
   logic [11:0]       rsp_pos_y;
   logic [12:0]       rsp_rect_width;
   logic [12:0]       rsp_rect_height;
   logic [7:0]        rsp_glyph_code;
   logic [23:0]       rsp_color;
   logic [2:0]        rsp_glyph_scale;
   logic              rsp_last;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   // Shadow registers, derived geometry and cursor
   logic [5:0]   cfg_gw, cfg_gh;
   logic [2:0]   cfg_scale;
   logic [12:0]  cfg_sw, cfg_sh;
   logic [23:0]  cfg_fg, cfg_bg;
   int unsigned  g_gw, g_gh, g_sc, g_sw, g_sh, g_cell, g_line, g_box_w, g_box_h;
   logic [11:0]  cur_x, cur_y;

   draw_cmd_type step_draws[$];
   draw_cmd_type pending_draws[$];
   stim_row_type issued_ops[$];
   int           err_count;
   int           draw_count;
   bit           idle_on;
   bit           rx_hold;

   stim_row_type directed_ops [NUM_DIRECTED] = '{
      '{OP_PUT,    8'h41,         10'd0,   10'd0,   1'b1, 1'b1, DRAW_A_AT_ORIGIN},
      '{OP_PUT,    PRINT_HI,      10'd0,   10'd0,   1'b0, 1'b0, NO_DRAW},
      '{OP_PUT,    CHR_SPACE,     10'd0,   10'd0,   1'b0, 1'b0, NO_DRAW},
      '{OP_PUT,    8'h00,         10'd0,   10'd0,   1'b1, 1'b0, NO_DRAW},
      '{OP_PUT,    8'h1F,         10'd0,   10'd0,   1'b1, 1'b0, NO_DRAW},
      '{OP_PUT,    8'h80,         10'd0,   10'd0,   1'b1, 1'b0, NO_DRAW},
      '{OP_PUT,    8'hFF,         10'd0,   10'd0,   1'b1, 1'b0, NO_DRAW},
      '{OP_NONE,   8'hFF,         10'h3FF, 10'h3FF, 1'b1, 1'b0, NO_DRAW},
      '{OP_PUT,    CHR_BACKSPACE, 10'd0,   10'd0,   1'b0, 1'b0, NO_DRAW},
      '{OP_PUT,    CHR_TAB,       10'd0,   10'd0,   1'b0, 1'b0, NO_DRAW},
      '{OP_PUT,    CHR_NEWLINE,   10'd0,   10'd0,   1'b0, 1'b0, NO_DRAW},
      '{OP_PUT,    CHR_BACKSPACE, 10'd0,   10'd0,   1'b0, 1'b0, NO_DRAW},
      '{OP_CLEAR,  8'h00,         10'd0,   10'd0,   1'b1, 1'b1, CLEAR_AT_RESET},
      '{OP_PUT,    CHR_BACKSPACE, 10'd0,   10'd0,   1'b1, 1'b0, NO_DRAW},
      '{OP_SETCUR, 8'h00,         10'h3FF, 10'h3FF, 1'b1, 1'b0, NO_DRAW},
      '{OP_PUT,    8'h5A,         10'd0,   10'd0,   1'b0, 1'b0, NO_DRAW},
      '{OP_PUT,    CHR_NEWLINE,   10'd0,   10'd0,   1'b0, 1'b0, NO_DRAW},
      '{OP_SETCUR, 8'h00,         10'd113, 10'd5,   1'b1, 1'b0, NO_DRAW},
      '{OP_PUT,    CHR_TAB,       10'd0,   10'd0,   1'b0, 1'b0, NO_DRAW},
      '{OP_SETCUR, 8'h00,         10'd0,   10'd1,   1'b1, 1'b0, NO_DRAW},
      '{OP_PUT,    CHR_BACKSPACE, 10'd0,   10'd0,   1'b0, 1'b0, NO_DRAW},
      '{OP_PUT,    8'h71,         10'd0,   10'd0,   1'b0, 1'b0, NO_DRAW},
      '{OP_CLEAR,  8'h00,         10'd0,   10'd0,   1'b1, 1'b1, CLEAR_AT_RESET}
   };

   text_console_cursor_engine_unit dut (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Recompute the saturated geometry from the shadow registers
   function automatic void geom_refresh();
      g_gw    = clamp_u(32'(cfg_gw), 1, 32);
      g_gh    = clamp_u(32'(cfg_gh), 1, 32);
      g_sc    = clamp_u(32'(cfg_scale), 1, 4);
      g_sw    = clamp_u(32'(cfg_sw), 1, 4096);
      g_sh    = clamp_u(32'(cfg_sh), 1, 4096);
      g_cell  = (g_gw + CHAR_GAP) * g_sc;
      g_line  = (g_gh + LINE_GAP) * g_sc;
      g_box_w = g_gw * g_sc;
      g_box_h = g_gh * g_sc;
   endfunction

   // Queue one command for the current op, dropping any past the per-op cap
   function automatic void emit_draw(out_cmd_type kind, int unsigned x, int unsigned y,
                                     int unsigned w, int unsigned h, int unsigned code,
                                     int unsigned color, int unsigned gscale);
      draw_cmd_type d;
      if (step_draws.size() >= MAX_CMDS) return;
      d.cmd    = kind;
      d.x      = x[11:0];
      d.y      = y[11:0];
      d.w      = w[12:0];
      d.h      = h[12:0];
      d.code   = code[7:0];
      d.color  = color[23:0];
      d.gscale = gscale[2:0];
      d.last   = 1'b0;
      step_draws.push_back(d);
   endfunction

   // Go to the start of the next line, scrolling at the bottom
   function automatic void line_feed();
      int unsigned y;
      y = cur_y + g_line;
      if (y + g_box_h > g_sh) begin
         emit_draw(CMD_SCROLL, 0, 0, 0, g_line, 0, cfg_bg, 1);
         y = y - g_line;
      end
      cur_x = '0;
      cur_y = y[11:0];
   endfunction

   function automatic void print_glyph(logic [7:0] ch);
      int unsigned x;
      emit_draw(CMD_GLYPH, cur_x, cur_y, 0, 0, ch, cfg_fg, g_sc);
      x = cur_x + g_cell;
      if (x + g_box_w > g_sw) line_feed();
      else cur_x = x[11:0];
   endfunction

   // Step back one cell, wrapping to the previous line at column zero
   function automatic void erase_cell();
      int unsigned x, y;
      x = cur_x;
      y = cur_y;
      if (x == 0 && y == 0) return;
      if (x == 0) begin
         if (y >= g_line) y = y - g_line;
         x = (g_sw > g_box_w) ? g_sw - g_box_w : 0;
      end else begin
         x = (x > g_cell) ? x - g_cell : 0;
      end
      cur_x = x[11:0];
      cur_y = y[11:0];
      emit_draw(CMD_FILL, cur_x, cur_y, g_box_w, g_box_h, 0, cfg_bg, 1);
   endfunction

   // Work out the commands one console op causes and move the cursor
   function automatic void console_step(logic [1:0] op, logic [7:0] ch,
                                        logic [9:0] col, logic [9:0] row);
      int unsigned x, y;
      draw_cmd_type tail;
      step_draws.delete();
      case (op_type'(op))
         OP_PUT: begin
            if (ch == CHR_NEWLINE) line_feed();
            else if (ch == CHR_TAB) begin
               for (int t = 0; t < TAB_SPACES; t++) print_glyph(CHR_SPACE);
            end else if (ch == CHR_BACKSPACE) erase_cell();
            else if (ch >= PRINT_LO && ch <= PRINT_HI) print_glyph(ch);
         end
         OP_SETCUR: begin
            x = int'(col) * g_cell;
            y = int'(row) * g_line;
            if (x >= g_sw) x = (g_sw > g_box_w) ? g_sw - g_box_w : 0;
            if (y >= g_sh) y = (g_sh > g_box_h) ? g_sh - g_box_h : 0;
            cur_x = x[11:0];
            cur_y = y[11:0];
         end
         OP_CLEAR: begin
            emit_draw(CMD_FILL, 0, 0, g_sw, g_sh, 0, cfg_bg, 1);
            cur_x = '0;
            cur_y = '0;
         end
         default: ;
      endcase
      if (step_draws.size() > 0) begin
         tail = step_draws.pop_back();
         tail.last = 1'b1;
         step_draws.push_back(tail);
      end
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      err_count++;
      if (err_count <= PRINT_LIMIT)
         $display("%0t ns draw %0d: %s got 0x%0h, expected 0x%0h",
                  $time, draw_count, what, got, want);
   endtask

   // Predict on accepted ops, then check each transferred command in order
   always @(posedge clock) begin : scoreboard
      stim_row_type op_row;
      draw_cmd_type want;
      if (reset === 1'b0) begin
         if (req_valid && req_ready) begin
            op_row = issued_ops.pop_front();
            console_step(req_opcode, req_char_code, req_column, req_row);
            if (op_row.typed) begin
               if (op_row.has_draw) pending_draws.push_back(op_row.draw);
            end else begin
               foreach (step_draws[i]) pending_draws.push_back(step_draws[i]);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_draws.size() == 0) begin
               report_mismatch("unexpected command", rsp_command, 0);
            end else begin
               want = pending_draws.pop_front();
               if (rsp_command !== want.cmd) report_mismatch("command", rsp_command, want.cmd);
               if (rsp_pos_x !== want.x) report_mismatch("pos_x", rsp_pos_x, want.x);
               if (rsp_pos_y !== want.y) report_mismatch("pos_y", rsp_pos_y, want.y);
               if (rsp_rect_width !== want.w)
                  report_mismatch("rect_width", rsp_rect_width, want.w);
               if (rsp_rect_height !== want.h)
                  report_mismatch("rect_height", rsp_rect_height, want.h);
               if (rsp_glyph_code !== want.code)
                  report_mismatch("glyph_code", rsp_glyph_code, want.code);
               if (rsp_color !== want.color) report_mismatch("color", rsp_color, want.color);
               if (rsp_glyph_scale !== want.gscale)
                  report_mismatch("glyph_scale", rsp_glyph_scale, want.gscale);
               if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
            end
            draw_count++;
         end
      end
   end

   // Result sink: random stalls, plus one long hold-off on request
   initial begin : result_sink
      int gap;
      rsp_ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rx_hold) begin
            rx_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = idle_on ? $urandom_range(0, 11) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid && !rx_hold);
      end
   end

   // End the run when nothing has moved for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
            idle = 0;
         else
            idle++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // One APB write; leaves the bus in access so a following write can chain
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'({idx, 2'b00});
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_GLYPH_W:    cfg_gw    = val[5:0];
         REG_GLYPH_H:    cfg_gh    = val[5:0];
         REG_SCALE:      cfg_scale = val[2:0];
         REG_SCREEN_W:   cfg_sw    = val[12:0];
         REG_SCREEN_H:   cfg_sh    = val[12:0];
         REG_FG_COLOR:   cfg_fg    = val[23:0];
         REG_BACK_COLOR: cfg_bg    = val[23:0];
         default: ;
      endcase
      geom_refresh();
   endtask

   task automatic write_geometry(input logic [5:0] gw, input logic [5:0] gh,
                                 input logic [2:0] sc, input logic [12:0] sw,
                                 input logic [12:0] sh, input logic [23:0] fg,
                                 input logic [23:0] bg);
      csr_write(REG_GLYPH_W, 32'(gw));
      csr_write(REG_GLYPH_H, 32'(gh));
      csr_write(REG_SCALE, 32'(sc));
      csr_write(REG_SCREEN_W, 32'(sw));
      csr_write(REG_SCREEN_H, 32'(sh));
      csr_write(REG_FG_COLOR, 32'(fg));
      csr_write(REG_BACK_COLOR, 32'(bg));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offer one op after a random gap; valid stays high across back-to-back ops
   task automatic send_item(input stim_row_type r);
      int gap;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      issued_ops.push_back(r);
      req_valid     <= 1'b1;
      req_opcode    <= r.op;
      req_char_code <= r.ch;
      req_column    <= r.col;
      req_row       <= r.row;
      do @(posedge clock); while (!req_ready);
   endtask

   // Mostly printable text, with control codes, cursor moves, clears and noise
   function automatic stim_row_type random_op();
      stim_row_type r;
      int pick;
      r     = '0;
      r.op  = OP_PUT;
      r.col = 10'($urandom);
      r.row = 10'($urandom);
      pick  = $urandom_range(0, 99);
      if (pick < 55) r.ch = 8'($urandom_range(PRINT_LO, PRINT_HI));
      else if (pick < 63) r.ch = CHR_NEWLINE;
      else if (pick < 71) r.ch = CHR_TAB;
      else if (pick < 81) r.ch = CHR_BACKSPACE;
      else if (pick < 87) begin
         r.op = OP_SETCUR;
         if ($urandom_range(0, 1) == 1) begin
            r.col = 10'($urandom_range(0, 20));
            r.row = 10'($urandom_range(0, 12));
         end
      end else if (pick < 91) r.op = OP_CLEAR;
      else if (pick < 96)
         r.ch = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(128, 255))
                                            : 8'($urandom_range(0, 31));
      else begin
         r.op = OP_NONE;
         r.ch = 8'($urandom);
      end
      return r;
   endfunction

   task automatic run_ops(input int count);
      for (int i = 0; i < count; i++) send_item(random_op());
   endtask

   // Drop valid, wait out every pending command, then let the engine go idle
   task automatic settle_console();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_opcode    <= '0;
      req_char_code <= '0;
      req_column    <= '0;
      req_row       <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      idle_on    = 1'b1;
      rx_hold    = 1'b0;
      err_count  = 0;
      draw_count = 0;
      cfg_gw     = RST_GLYPH_W;
      cfg_gh     = RST_GLYPH_H;
      cfg_scale  = RST_SCALE;
      cfg_sw     = RST_SCREEN_W;
      cfg_sh     = RST_SCREEN_H;
      cfg_fg     = RST_FG_COLOR;
      cfg_bg     = RST_BACK_COLOR;
      cur_x      = '0;
      cur_y      = '0;
      geom_refresh();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at reset geometry
      foreach (directed_ops[i]) send_item(directed_ops[i]);

      // Flood while the sink holds off, then pause until all commands are out
      idle_on = 1'b0;
      rx_hold = 1'b1;
      run_ops(16);
      settle_console();
      idle_on = 1'b1;
      run_ops(14);
      settle_console();

      // Field maxima: everything saturates to the largest geometry
      idle_on = ($urandom_range(0, 2) != 0);
      write_geometry(6'h3F, 6'h3F, 3'h7, 13'h1FFF, 13'h1FFF, 24'h000000, 24'hFFFFFF);
      run_ops(18);
      settle_console();

      // Field zeros: one-pixel screen, every glyph wraps and scrolls
      idle_on = 1'b1;
      write_geometry(6'd0, 6'd0, 3'd0, 13'd0, 13'd0, 24'hFFFFFF, 24'h000000);
      run_ops(14);
      settle_console();

      // Upper and lower ends of the legal ranges
      idle_on = ($urandom_range(0, 2) != 0);
      write_geometry(6'd32, 6'd32, 3'd4, 13'd4096, 13'd4096, 24'($urandom), 24'($urandom));
      run_ops(14);
      settle_console();
      idle_on = ($urandom_range(0, 2) != 0);
      write_geometry(6'd1, 6'd1, 3'd1, 13'd1, 13'd1, 24'($urandom), 24'($urandom));
      run_ops(14);
      settle_console();

      // Random geometry, often with a small screen to hit wrap and scroll
      for (int p = 0; p < 3; p++) begin
         idle_on = ($urandom_range(0, 2) != 0);
         write_geometry(6'($urandom_range(1, 32)), 6'($urandom_range(1, 32)),
                        3'($urandom_range(1, 4)),
                        ($urandom_range(0, 1) == 1) ? 13'($urandom_range(1, 120))
                                                    : 13'($urandom_range(120, 4096)),
                        ($urandom_range(0, 1) == 1) ? 13'($urandom_range(1, 120))
                                                    : 13'($urandom_range(120, 4096)),
                        24'($urandom), 24'($urandom));
         run_ops(18);
         settle_console();
      end

      if (err_count == 0 && pending_draws.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== text_console_cursor_engine_unit.f =====
rtl/core/tcce_pkg.sv
rtl/core/tcce_regs.sv
rtl/core/tcce_dp.sv
rtl/core/tcce_ctrl.sv
rtl/core/text_console_cursor_engine_unit.sv
dv/text_console_cursor_engine_unit_tb.sv
